[rtl/npd_pkg.sv]
// Shared types and constants for the neighbourhood pattern dictionary.
`timescale 1ns / 1ps
package npd_pkg;

   localparam int CELL_W   = 8;
   localparam int CELLS    = 9;
   localparam int WIN_W    = CELL_W * CELLS;
   localparam int LABEL_W  = 8;
   localparam int SLOT_W   = WIN_W + LABEL_W;
   localparam int CENTER_LSB = 4 * CELL_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic REG_WALL_CODE  = 1'b0;
   localparam logic REG_LABEL_BASE = 1'b1;

   localparam logic [CELL_W-1:0]  WALL_CODE_RST  = 8'd48;
   localparam logic [LABEL_W-1:0] LABEL_BASE_RST = 8'd65;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

[rtl/npd_store.sv]
// Pattern store: one write port, one registered read port.
`timescale 1ns / 1ps
module npd_store #(
   parameter int ENTRIES = 128
) (
   input  logic                           clock,
   input  npd_pkg::mem_ctl_type           ctl,
   input  logic [$clog2(ENTRIES)-1:0]     rd_addr,
   input  logic [$clog2(ENTRIES)-1:0]     wr_addr,
   input  logic [npd_pkg::SLOT_W-1:0]     wr_slot,
   output logic [npd_pkg::SLOT_W-1:0]     rd_slot
);
   import npd_pkg::*;

   logic [SLOT_W-1:0] store_ff [ENTRIES];
   logic [SLOT_W-1:0] rd_slot_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_slot_ff <= store_ff[rd_addr];
      end
   end

   assign rd_slot = rd_slot_ff;

endmodule

[rtl/npd_seq.sv]
// Search sequencer: window compare unit, fill count and result register.
`timescale 1ns / 1ps
module npd_seq #(
   parameter int ENTRIES = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [npd_pkg::CELL_W-1:0]     wall_code,
   input  logic [npd_pkg::LABEL_W-1:0]    label_base,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [npd_pkg::WIN_W-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [npd_pkg::LABEL_W-1:0]    rsp_label,
   output logic                           rsp_known,
   output logic                           rsp_full,
   output npd_pkg::mem_ctl_type           mem_ctl,
   output logic [$clog2(ENTRIES)-1:0]     mem_rd_addr,
   output logic [$clog2(ENTRIES)-1:0]     mem_wr_addr,
   output logic [npd_pkg::SLOT_W-1:0]     mem_wr_slot,
   input  logic [npd_pkg::SLOT_W-1:0]     mem_rd_slot
);
   import npd_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic [LABEL_W-1:0] res_label_ff, res_label_in;
   logic               res_known_ff, res_known_in;
   logic               res_full_ff, res_full_in;
   logic               out_vld_ff, out_vld_in;
   logic [LABEL_W-1:0] out_label_ff, out_label_in;
   logic               out_known_ff, out_known_in;
   logic               out_full_ff, out_full_in;

   logic               accept;
   logic               is_wall;
   logic               match;
   logic               issue;
   logic               hit;
   logic               miss;
   logic               full;
   logic               out_take;
   logic [LABEL_W-1:0] new_label;

   // shared compare unit: one stored window per cycle
   assign match     = (mem_rd_slot[WIN_W-1:0] == win_ff);
   assign is_wall   = (req_tdata[CENTER_LSB +: CELL_W] == wall_code);
   assign full      = (count_ff == CW'(ENTRIES));
   assign new_label = label_base + LABEL_W'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_wall ? ST_SEARCH : ST_RESULT;
            end
         end
         ST_SEARCH: begin
            if (hit || miss) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      hit        = 1'b0;
      miss       = 1'b0;
      out_take   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SEARCH: begin
            hit   = cmp_vld_ff && match;
            miss  = (idx_ff == count_ff) && !hit;
            issue = (idx_ff != count_ff) && !hit;
         end
         ST_RESULT: begin
            out_take = !out_vld_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   assign mem_ctl.rd_en = issue;
   assign mem_ctl.wr_en = miss && !full;
   assign mem_rd_addr   = idx_ff[IW-1:0];
   assign mem_wr_addr   = count_ff[IW-1:0];
   assign mem_wr_slot   = {new_label, win_ff};

   // datapath next values
   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      cmp_vld_in   = cmp_vld_ff;
      win_in       = win_ff;
      res_label_in = res_label_ff;
      res_known_in = res_known_ff;
      res_full_in  = res_full_ff;
      if (accept) begin
         win_in       = req_tdata;
         idx_in       = '0;
         cmp_vld_in   = 1'b0;
         res_label_in = req_tdata[CENTER_LSB +: CELL_W];
         res_known_in = 1'b0;
         res_full_in  = 1'b0;
      end
      if (state_ff == ST_SEARCH) begin
         cmp_vld_in = issue;
         if (issue) begin
            idx_in = idx_ff + CW'(1);
         end
      end
      if (hit) begin
         res_label_in = mem_rd_slot[SLOT_W-1 -: LABEL_W];
         res_known_in = 1'b1;
         res_full_in  = 1'b0;
      end
      if (miss) begin
         res_known_in = 1'b0;
         if (full) begin
            res_label_in = '0;
            res_full_in  = 1'b1;
         end else begin
            res_label_in = new_label;
            res_full_in  = 1'b0;
            count_in     = count_ff + CW'(1);
         end
      end
   end

   // output register
   always_comb begin
      out_vld_in   = out_vld_ff;
      out_label_in = out_label_ff;
      out_known_in = out_known_ff;
      out_full_in  = out_full_ff;
      if (out_take) begin
         out_vld_in   = 1'b1;
         out_label_in = res_label_ff;
         out_known_in = res_known_ff;
         out_full_in  = res_full_ff;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      win_ff       <= win_in;
      res_label_ff <= res_label_in;
      res_known_ff <= res_known_in;
      res_full_ff  <= res_full_in;
      out_label_ff <= out_label_in;
      out_known_ff <= out_known_in;
      out_full_ff  <= out_full_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_label  = out_label_ff;
   assign rsp_known  = out_known_ff;
   assign rsp_full   = out_full_ff;

endmodule

[rtl/neighbourhood_pattern_dictionary_core.sv]
// Top level: neighbourhood pattern dictionary with CSR port.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_tvalid/req_tready  | tdata: nine 8-bit cells
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: label, tuser: flags
//  csr     | in/out    | psel/penable, pready=1 | wall_code @0x0, label_base @0x4
//
//  Non-wall item: the centre cell is taken as the result label at accept and
//  moved into the output register once that register is free or being taken.
//  Wall item: one stored window per cycle through the single read port, registered read.
//  One item at a time; the output register lets the next item enter while
//  a result still waits on rsp_tready. No clearing pass: entries at or above
//  the fill count are never read. Reset is synchronous and clears control only.
//
module neighbourhood_pattern_dictionary_core #(
   parameter int ENTRIES = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   // req: item in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cell_nw, cell_n, cell_ne, cell_w, cell_c, cell_e, cell_sw, cell_s, cell_se
   input  logic [npd_pkg::WIN_W-1:0]          req_tdata,
   // rsp: item out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // label
   output logic [npd_pkg::LABEL_W-1:0]        rsp_tdata,
   // was_known, table_full
   output logic [1:0]                         rsp_tuser,
   // csr: APB-style register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [npd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [npd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [npd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import npd_pkg::*;

   localparam int IW = $clog2(ENTRIES);

   logic [CELL_W-1:0]  wall_code_ff, wall_code_in;
   logic [LABEL_W-1:0] label_base_ff, label_base_in;
   logic               csr_wr;
   logic               reg_sel;

   mem_ctl_type        mem_ctl;
   logic [IW-1:0]      mem_rd_addr;
   logic [IW-1:0]      mem_wr_addr;
   logic [SLOT_W-1:0]  mem_wr_slot;
   logic [SLOT_W-1:0]  mem_rd_slot;

   // register file; word index is paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      wall_code_in  = wall_code_ff;
      label_base_in = label_base_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_WALL_CODE:  wall_code_in  = csr_pwdata[CELL_W-1:0];
            REG_LABEL_BASE: label_base_in = csr_pwdata[LABEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WALL_CODE:  csr_prdata = CSR_DATA_W'(wall_code_ff);
         REG_LABEL_BASE: csr_prdata = CSR_DATA_W'(label_base_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_code_ff  <= WALL_CODE_RST;
         label_base_ff <= LABEL_BASE_RST;
      end else begin
         wall_code_ff  <= wall_code_in;
         label_base_ff <= label_base_in;
      end
   end

   // sequencer with the shared window comparator
   npd_seq #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .wall_code   (wall_code_ff),
      .label_base  (label_base_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_label   (rsp_tdata),
      .rsp_known   (rsp_tuser[0]),
      .rsp_full    (rsp_tuser[1]),
      .mem_ctl     (mem_ctl),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_slot (mem_wr_slot),
      .mem_rd_slot (mem_rd_slot)
   );

   // stored windows with their labels
   npd_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_slot (mem_wr_slot),
      .rd_slot (mem_rd_slot)
   );

endmodule

[bench/tb_top.sv]
// Self-checking bench for neighbourhood_pattern_dictionary_core: directed and random windows.
`timescale 1ns / 1ps
module tb_top;
   import npd_pkg::*;

   // Block geometry and bench knobs.
   localparam int ENTRIES     = 128;
   localparam int IDLE_PCT    = 12;
   // Worst legal gap between accepts: a full search behind a stalled result plus
   // sender gaps, taken several times over.
   localparam int STALL_LIMIT = 8 * (ENTRIES + 3) + 1000;

   // Byte addresses of the two CSRs; the register index sits in paddr[2].
   localparam logic [CSR_ADDR_W-1:0] ADDR_WALL_CODE  = {REG_WALL_CODE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_LABEL_BASE = {REG_LABEL_BASE, 2'b00};

   typedef logic [WIN_W-1:0] window_type;

   // One expected result: label plus the two flags carried on rsp_tuser.
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               was_known;
      logic               table_full;
   } verdict_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // cell_nw, cell_n, cell_ne, cell_w, cell_c, cell_e, cell_sw, cell_s, cell_se
   logic [WIN_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // label
   logic [LABEL_W-1:0]    rsp_tdata;
   // was_known, table_full
   logic [1:0]            rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   neighbourhood_pattern_dictionary_core #(
      .ENTRIES(ENTRIES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------ dictionary shadow
   // Bench copy of the CSRs and the pattern table, updated in accept order.
   logic [CELL_W-1:0]  wall_code_q;
   logic [LABEL_W-1:0] label_base_q;
   window_type         stored_windows [ENTRIES];
   logic [LABEL_W-1:0] stored_labels  [ENTRIES];
   int                 stored_count;

   verdict_type        pending_labels [$];   // labels still owed by the block
   int                 mismatches;
   int                 idle_pct;             // shared by sender and receiver
   int                 stalled_cycles;

   // Classify one window and, on a miss with room, append it to the table.
   function automatic verdict_type classify_window(input window_type win);
      verdict_type v;
      int          k;
      v = '0;
      // Centre not the wall code: plain pass-through, table untouched.
      if (win[CENTER_LSB +: CELL_W] != wall_code_q) begin
         v.label = win[CENTER_LSB +: CELL_W];
         return v;
      end
      // First exact match on all nine cells wins.
      for (k = 0; k < stored_count; k++) begin
         if (stored_windows[k] == win) begin
            v.label     = stored_labels[k];
            v.was_known = 1'b1;
            return v;
         end
      end
      // Full table: miss is flagged, label stays zero.
      if (stored_count >= ENTRIES) begin
         v.table_full = 1'b1;
         return v;
      end
      // New entry: label wraps mod 256 and is frozen at store time.
      v.label = label_base_q + stored_count[LABEL_W-1:0];
      stored_windows[stored_count] = win;
      stored_labels[stored_count]  = v.label;
      stored_count++;
      return v;
   endfunction

   // ---------------------------------------------------------- window makers
   function automatic window_type uniform_window(input logic [CELL_W-1:0] fill,
                                                 input logic [CELL_W-1:0] centre);
      window_type w;
      int         c;
      for (c = 0; c < CELLS; c++)
         w[c*CELL_W +: CELL_W] = fill;
      w[CENTER_LSB +: CELL_W] = centre;
      return w;
   endfunction

   function automatic window_type fresh_wall_window();
      window_type w;
      int         c;
      for (c = 0; c < CELLS; c++)
         w[c*CELL_W +: CELL_W] = CELL_W'($urandom);
      w[CENTER_LSB +: CELL_W] = wall_code_q;
      return w;
   endfunction

   // Random mix: mostly wall windows that reach the search (repeats hit,
   // near copies and fresh ones miss), the rest pass straight through.
   function automatic window_type pick_window();
      window_type w;
      int         roll;
      int         pos;
      int         k;
      int         picks [$];
      roll = $urandom_range(99);
      for (k = 0; k < stored_count; k++)
         if (stored_windows[k][CENTER_LSB +: CELL_W] == wall_code_q)
            picks.push_back(k);
      if (roll < 35) begin
         w = fresh_wall_window();
         w[CENTER_LSB +: CELL_W] = CELL_W'($urandom);
         if (w[CENTER_LSB +: CELL_W] == wall_code_q)
            w[CENTER_LSB + $urandom_range(CELL_W-1)] ^= 1'b1;
      end else if (roll < 85 && picks.size() != 0) begin
         w = stored_windows[picks[$urandom_range(picks.size()-1)]];
      end else if (roll < 90 && picks.size() != 0) begin
         // one bit off in a neighbour cell, centre kept on the wall code
         w   = stored_windows[picks[$urandom_range(picks.size()-1)]];
         pos = $urandom_range(WIN_W - CELL_W - 1);
         if (pos >= CENTER_LSB)
            pos += CELL_W;
         w[pos] = ~w[pos];
      end else begin
         w = fresh_wall_window();
      end
      return w;
   endfunction

   // ------------------------------------------------------------ bus drivers
   task automatic report_mismatch(input string what);
      // keep the log short on a badly broken block
      if (mismatches < 100)
         $display("tb_top: mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Offer one item; valid stays high after the accept so a following item
   // can go out back to back.
   task automatic send_window(input window_type win);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= win;
      do @(posedge clock); while (!req_tready);
      pending_labels.push_back(classify_window(win));
   endtask

   // Drop valid and let every owed result come back before touching CSRs.
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_labels.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup then access phase; psel is released by the caller so that
   // back-to-back writes assign each signal once per edge.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CELL_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {24'($urandom), value};   // upper bits must be ignored
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_WALL_CODE)
         wall_code_q = value;
      else if (addr == ADDR_LABEL_BASE)
         label_base_q = value;
   endtask

   task automatic set_config(input logic [CELL_W-1:0] wall, input logic [LABEL_W-1:0] base);
      wait_drained();
      write_reg(ADDR_WALL_CODE, wall);
      write_reg(ADDR_LABEL_BASE, base);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // -------------------------------------------------------------- the tests
   // Centre off the wall code: centre comes back as the label.
   task automatic test_passthrough;
      send_window(uniform_window(8'h00, 8'h00));
      send_window(uniform_window(8'hFF, 8'hFF));
      send_window(uniform_window(WALL_CODE_RST, WALL_CODE_RST - 8'd1));
      send_window(uniform_window(8'h00, WALL_CODE_RST + 8'd1));
   endtask

   // Fill the first entries from reset values, then hit them again.
   task automatic test_new_and_known;
      window_type w;
      send_window(uniform_window(WALL_CODE_RST, WALL_CODE_RST));   // first entry
      send_window(uniform_window(WALL_CODE_RST, WALL_CODE_RST));   // hit on it
      send_window(uniform_window(8'hFF, WALL_CODE_RST));
      send_window(uniform_window(8'h00, WALL_CODE_RST));
      send_window(uniform_window(8'hFF, WALL_CODE_RST));
      // differ only in the last cell, then only in the first cell
      w = uniform_window(WALL_CODE_RST, WALL_CODE_RST);
      w[WIN_W-CELL_W +: CELL_W] = WALL_CODE_RST + 8'd1;
      send_window(w);
      w = uniform_window(WALL_CODE_RST, WALL_CODE_RST);
      w[0 +: CELL_W] = WALL_CODE_RST - 8'd1;
      send_window(w);
   endtask

   // Label wraps past 255; stored labels survive a later base change.
   task automatic test_label_wrap;
      set_config(8'h00, 8'hFF);
      send_window(uniform_window(8'h00, 8'h00));                   // miss, wrapped label
      send_window(uniform_window(8'h00, 8'h00));                   // hit
      send_window(uniform_window(WALL_CODE_RST, WALL_CODE_RST));   // no longer wall
      set_config(WALL_CODE_RST, 8'hFF);
      send_window(uniform_window(WALL_CODE_RST, WALL_CODE_RST));   // old label kept
      send_window(fresh_wall_window());
   endtask

   task automatic run_random_phase(input logic [CELL_W-1:0] wall,
                                   input logic [LABEL_W-1:0] base,
                                   input int count, input bit steady);
      set_config(wall, base);
      idle_pct = steady ? 0 : IDLE_PCT;
      repeat (count) send_window(pick_window());
      idle_pct = IDLE_PCT;
   endtask

   // Several settings, extremes included; one phase runs with no idling.
   task automatic test_random_mix;
      run_random_phase(CELL_W'($urandom), LABEL_W'($urandom), 170, 1'b0);
      run_random_phase(8'h00, 8'h00, 170, 1'b0);
      run_random_phase(8'hFF, 8'hFF, 170, 1'b1);
      run_random_phase(WALL_CODE_RST, LABEL_BASE_RST, 170, 1'b0);
      run_random_phase(CELL_W'($urandom), LABEL_BASE_RST, 170, 1'b0);
      run_random_phase(WALL_CODE_RST, LABEL_W'($urandom), 170, 1'b0);
   endtask

   // Top the table up, overflow it, and keep going once it is full.
   task automatic test_table_full;
      set_config(CELL_W'($urandom), LABEL_W'($urandom));
      while (stored_count < ENTRIES)
         send_window(fresh_wall_window());
      repeat (8) send_window(fresh_wall_window());
      repeat (8) send_window(stored_windows[$urandom_range(ENTRIES-1)]);
      run_random_phase(wall_code_q, 8'hFF, 250, 1'b0);
   endtask

   // ------------------------------------------------------- result checking
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_labels.size() == 0) begin
               report_mismatch($sformatf("result label %0d with nothing owed", rsp_tdata));
            end else begin
               want = pending_labels.pop_front();
               if (rsp_tdata !== want.label)
                  report_mismatch($sformatf("label %0d, want %0d", rsp_tdata, want.label));
               if (rsp_tuser[0] !== want.was_known)
                  report_mismatch($sformatf("was_known %b, want %b",
                                            rsp_tuser[0], want.was_known));
               if (rsp_tuser[1] !== want.table_full)
                  report_mismatch($sformatf("table_full %b, want %b",
                                            rsp_tuser[1], want.table_full));
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // ---------------------------------------------------------------- watchdog
   // Counts edges with no accept on any port.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------ test flow
   initial begin
      wall_code_q  = WALL_CODE_RST;
      label_base_q = LABEL_BASE_RST;
      stored_count = 0;
      mismatches   = 0;
      idle_pct     = IDLE_PCT;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_passthrough();
      test_new_and_known();
      test_label_wrap();
      test_random_mix();
      test_table_full();

      // drain, then give a late or spurious result time to show up
      wait_drained();
      repeat (ENTRIES + 8) @(posedge clock);
      if (mismatches == 0 && pending_labels.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
